[hdl/tcrb_pkg.sv]
// Shared types and constants for the trace capture ring buffer.
// No dependencies; used by trace_capture_ring_buffer_unit.
`default_nettype none

package tcrb_pkg;

  // Default sizing
  localparam int DEPTH_DEFAULT      = 1024;
  localparam int NEST_LIMIT_DEFAULT = 255;

  // Fixed field widths
  localparam int OP_W     = 3;
  localparam int STATUS_W = 3;
  localparam int POS_W    = 10;
  localparam int HELD_W   = 11;
  localparam int TOTAL_W  = 64;
  localparam int ADDR_W   = 64;
  localparam int THREAD_W = 31;
  localparam int NAME_LO_W = 64;
  localparam int NAME_HI_W = 56;

  // Op codes
  localparam logic [OP_W-1:0] OP_RECORD  = 3'd0;
  localparam logic [OP_W-1:0] OP_POP     = 3'd1;
  localparam logic [OP_W-1:0] OP_PEEK    = 3'd2;
  localparam logic [OP_W-1:0] OP_CLEAR   = 3'd3;
  localparam logic [OP_W-1:0] OP_DISABLE = 3'd4;
  localparam logic [OP_W-1:0] OP_ENABLE  = 3'd5;

  // Status codes
  localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
  localparam logic [STATUS_W-1:0] ST_FULL     = 3'd1;
  localparam logic [STATUS_W-1:0] ST_DISABLED = 3'd2;
  localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd3;
  localparam logic [STATUS_W-1:0] ST_BEYOND   = 3'd4;
  localparam logic [STATUS_W-1:0] ST_LIMIT    = 3'd5;

  // One stored call record
  typedef struct packed {
    logic [ADDR_W-1:0]    ip;
    logic [ADDR_W-1:0]    caller;
    logic [ADDR_W-1:0]    stamp;
    logic [THREAD_W-1:0]  thread;
    logic [NAME_LO_W-1:0] name_lo;
    logic [NAME_HI_W-1:0] name_hi;
  } record_t;

endpackage

`default_nettype wire

[hdl/tcrb_ram.sv]
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module tcrb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read, holds when not enabled
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

[hdl/trace_capture_ring_buffer_unit.sv]
// Trace capture ring buffer: an accepted input word is registered in stage 1 and then in the
// output word register. Throughput one word per cycle unless out_ready stalls the output;
// pointers and counters update in the accept cycle, record data comes back through the
// record RAM's registered read. Reset clears pointers, counters, nesting depth, capture
// enable and pipeline valids; record RAM contents are not cleared (only held entries are
// ever read). Depends on tcrb_pkg and tcrb_ram.
`default_nettype none

module trace_capture_ring_buffer_unit #(
  parameter int DEPTH      = tcrb_pkg::DEPTH_DEFAULT,
  parameter int NEST_LIMIT = tcrb_pkg::NEST_LIMIT_DEFAULT
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  // configuration channel
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic                           cfg_data,
  // input channel
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic [tcrb_pkg::OP_W-1:0]      op,
  input  wire logic [tcrb_pkg::ADDR_W-1:0]    call_ip,
  input  wire logic [tcrb_pkg::ADDR_W-1:0]    caller_ip,
  input  wire logic [tcrb_pkg::ADDR_W-1:0]    time_stamp,
  input  wire logic [tcrb_pkg::THREAD_W-1:0]  thread_id,
  input  wire logic [tcrb_pkg::NAME_LO_W-1:0] task_name_low,
  input  wire logic [tcrb_pkg::NAME_HI_W-1:0] task_name_high,
  input  wire logic [tcrb_pkg::POS_W-1:0]     position,
  // output channel
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic      [tcrb_pkg::STATUS_W-1:0]  status,
  output logic      [tcrb_pkg::ADDR_W-1:0]    out_ip,
  output logic      [tcrb_pkg::ADDR_W-1:0]    out_caller_ip,
  output logic      [tcrb_pkg::ADDR_W-1:0]    out_time_stamp,
  output logic      [tcrb_pkg::THREAD_W-1:0]  out_thread_id,
  output logic      [tcrb_pkg::NAME_LO_W-1:0] out_name_low,
  output logic      [tcrb_pkg::NAME_HI_W-1:0] out_name_high,
  output logic      [tcrb_pkg::HELD_W-1:0]    entries_held,
  output logic      [tcrb_pkg::TOTAL_W-1:0]   entries_written_total
);

  localparam int AW   = $clog2(DEPTH);
  localparam int CW   = $clog2(DEPTH + 1);
  localparam int DW   = $clog2(NEST_LIMIT + 1);
  localparam int SW   = ((AW > tcrb_pkg::POS_W) ? AW : tcrb_pkg::POS_W) + 1;
  localparam int CMPW = (CW > tcrb_pkg::POS_W) ? CW : tcrb_pkg::POS_W;
  localparam int HW   = (CW > tcrb_pkg::HELD_W) ? CW : tcrb_pkg::HELD_W;
  localparam int RW   = $bits(tcrb_pkg::record_t);

  // architectural state
  logic                          capture_enable;
  logic [AW-1:0]                 read_pointer, read_pointer_next;
  logic [AW-1:0]                 write_pointer, write_pointer_next;
  logic [CW-1:0]                 entry_count, entry_count_next;
  logic [tcrb_pkg::TOTAL_W-1:0]  written_total, written_total_next;
  logic [DW-1:0]                 disable_depth, disable_depth_next;

  // stage 1: RAM read in flight
  logic                          s1_valid;
  logic                          s1_hit;
  logic [tcrb_pkg::STATUS_W-1:0] s1_status;
  logic [tcrb_pkg::HELD_W-1:0]   s1_held;
  logic [tcrb_pkg::TOTAL_W-1:0]  s1_total;

  logic                          accept;
  logic                          advance;
  logic [tcrb_pkg::STATUS_W-1:0] status_next;
  logic                          hit_next;
  logic                          ram_we;
  logic                          ram_re;
  logic [AW-1:0]                 ram_raddr;
  tcrb_pkg::record_t             wr_rec;
  tcrb_pkg::record_t             rd_rec;
  logic [SW-1:0]                 peek_sum;
  logic [SW-1:0]                 peek_wrap;
  logic [AW-1:0]                 peek_addr;
  logic                          rec_enabled;
  logic                          is_full;
  logic                          is_empty;
  logic                          pos_beyond;
  logic [HW-1:0]                 held_ext;

  // handshakes
  assign cfg_ready = 1'b1;
  assign advance   = s1_valid && (!out_valid || out_ready);
  assign in_ready  = !s1_valid || !out_valid || out_ready;
  assign accept    = in_valid && in_ready;

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      capture_enable <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      capture_enable <= cfg_data;
    end
  end

  // condition flags
  assign rec_enabled = capture_enable && (disable_depth == '0);
  assign is_full     = (entry_count == CW'(DEPTH));
  assign is_empty    = (entry_count == '0);
  assign pos_beyond  = (CMPW'(position) >= CMPW'(entry_count));

  // peek address: read pointer plus position, wrapped once
  assign peek_sum  = SW'(read_pointer) + SW'(position);
  assign peek_wrap = (peek_sum >= SW'(DEPTH)) ? (peek_sum - SW'(DEPTH)) : peek_sum;
  assign peek_addr = peek_wrap[AW-1:0];

  // record to store
  assign wr_rec.ip      = call_ip;
  assign wr_rec.caller  = caller_ip;
  assign wr_rec.stamp   = time_stamp;
  assign wr_rec.thread  = thread_id;
  assign wr_rec.name_lo = task_name_low;
  assign wr_rec.name_hi = task_name_high;

  // op decode and next state
  always_comb begin
    read_pointer_next  = read_pointer;
    write_pointer_next = write_pointer;
    entry_count_next   = entry_count;
    written_total_next = written_total;
    disable_depth_next = disable_depth;
    status_next        = tcrb_pkg::ST_OK;
    hit_next           = 1'b0;
    ram_we             = 1'b0;
    ram_re             = 1'b0;
    ram_raddr          = read_pointer;
    unique case (op)
      tcrb_pkg::OP_RECORD: begin
        if (!rec_enabled) begin
          status_next = tcrb_pkg::ST_DISABLED;
        end else if (is_full) begin
          status_next = tcrb_pkg::ST_FULL;
        end else begin
          ram_we             = accept;
          write_pointer_next = (write_pointer == AW'(DEPTH - 1)) ? '0 : write_pointer + 1'b1;
          entry_count_next   = entry_count + 1'b1;
          written_total_next = written_total + 1'b1;
        end
      end
      tcrb_pkg::OP_POP: begin
        if (is_empty) begin
          status_next = tcrb_pkg::ST_EMPTY;
        end else begin
          hit_next          = 1'b1;
          ram_re            = accept;
          read_pointer_next = (read_pointer == AW'(DEPTH - 1)) ? '0 : read_pointer + 1'b1;
          entry_count_next  = entry_count - 1'b1;
        end
      end
      tcrb_pkg::OP_PEEK: begin
        if (is_empty) begin
          status_next = tcrb_pkg::ST_EMPTY;
        end else if (pos_beyond) begin
          status_next = tcrb_pkg::ST_BEYOND;
        end else begin
          hit_next  = 1'b1;
          ram_re    = accept;
          ram_raddr = peek_addr;
        end
      end
      tcrb_pkg::OP_CLEAR: begin
        read_pointer_next  = '0;
        write_pointer_next = '0;
        entry_count_next   = '0;
        written_total_next = '0;
        disable_depth_next = '0;
      end
      tcrb_pkg::OP_DISABLE: begin
        if (disable_depth == DW'(NEST_LIMIT)) begin
          status_next = tcrb_pkg::ST_LIMIT;
        end else begin
          disable_depth_next = disable_depth + 1'b1;
        end
      end
      tcrb_pkg::OP_ENABLE: begin
        if (disable_depth == '0) begin
          status_next = tcrb_pkg::ST_LIMIT;
        end else begin
          disable_depth_next = disable_depth - 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  assign held_ext = HW'(entry_count_next);

  // state update on accept
  always_ff @(posedge clk) begin
    if (rst) begin
      read_pointer  <= '0;
      write_pointer <= '0;
      entry_count   <= '0;
      written_total <= '0;
      disable_depth <= '0;
    end else if (accept) begin
      read_pointer  <= read_pointer_next;
      write_pointer <= write_pointer_next;
      entry_count   <= entry_count_next;
      written_total <= written_total_next;
      disable_depth <= disable_depth_next;
    end
  end

  // record storage
  tcrb_ram #(
    .WIDTH (RW),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (write_pointer),
    .wdata (wr_rec),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (rd_rec)
  );

  // stage 1 control
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  // stage 1 payload
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_hit    <= hit_next;
      s1_status <= status_next;
      s1_held   <= held_ext[tcrb_pkg::HELD_W-1:0];
      s1_total  <= written_total_next;
    end
  end

  // output word valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // output word payload; record fields are zero unless a record is returned
  always_ff @(posedge clk) begin
    if (advance) begin
      status                <= s1_status;
      entries_held          <= s1_held;
      entries_written_total <= s1_total;
      out_ip                <= s1_hit ? rd_rec.ip      : '0;
      out_caller_ip         <= s1_hit ? rd_rec.caller  : '0;
      out_time_stamp        <= s1_hit ? rd_rec.stamp   : '0;
      out_thread_id         <= s1_hit ? rd_rec.thread  : '0;
      out_name_low          <= s1_hit ? rd_rec.name_lo : '0;
      out_name_high         <= s1_hit ? rd_rec.name_hi : '0;
    end
  end

endmodule

`default_nettype wire
